// ===== rtl/lkr_pkg.sv =====
// Package with shared operation codes, status codes, reset history depth and controller states of the LRU-K replacer.
package lkr_pkg;

    // Operation codes of an input transaction.
    localparam logic [1:0] OP_PIN    = 2'd0;
    localparam logic [1:0] OP_UNPIN  = 2'd1;
    localparam logic [1:0] OP_VICTIM = 2'd2;

    // Status codes of a result transaction.
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_EMPTY   = 2'd1;
    localparam logic [1:0] STATUS_UNKNOWN = 2'd2;

    // Reset value of the history depth register.
    localparam logic [3:0] K_RESET = 4'd2;

    // Controller states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_OP,
        ST_SCAN,
        ST_VICT,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/lkr_if.sv =====
// Channel interfaces of the LRU-K replacer: configuration, request and result.

interface lkr_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] history_depth_k;
    modport source (output valid, output history_depth_k, input ready);
    modport sink (input valid, input history_depth_k, output ready);
endinterface

interface lkr_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [5:0] frame;
    modport source (output valid, output operation, output frame, input ready);
    modport sink (input valid, input operation, input frame, output ready);
endinterface

interface lkr_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [5:0] victim_frame;
    logic [6:0] evictable_count;
    modport source (output valid, output status, output victim_frame,
                    output evictable_count, input ready);
    modport sink (input valid, input status, input victim_frame,
                  input evictable_count, output ready);
endinterface

// ===== rtl/lru_k_frame_replacer_top.sv =====
// LRU-K frame replacer: per-frame metadata RAM, per-frame ring of stamps in a stamp RAM.
// Pin and unpin pass ST_OP, then ST_DONE; unused codes and out-of-range frames go to
// ST_DONE at once; a victim request does one metadata RAM read per frame in ST_SCAN,
// then ST_VICT and ST_DONE. One transaction at a time: the next request is taken after
// ST_DONE, which waits for a free result register. Reset (rst_n low, asynchronous)
// clears the metadata RAM; requests are accepted after it, configuration writes always.
module lru_k_frame_replacer_top
    import lkr_pkg::*;
#(
    parameter int FRAMES      = 64,
    parameter int K_MAX       = 8,
    parameter int STAMP_WIDTH = 32
)
(
    input  logic  clk,
    input  logic  rst_n,
    lkr_cfg_if.sink      cfg,
    lkr_item_if.sink     item,
    lkr_result_if.source result
);

    localparam int FW  = $clog2(FRAMES);
    localparam int CW  = $clog2(FRAMES + 1);
    localparam int FLW = $clog2(K_MAX + 1);
    localparam int SW  = (K_MAX > 1) ? $clog2(K_MAX) : 1;
    localparam int DW  = $clog2(2 * K_MAX + 1);
    localparam int SAW = $clog2(FRAMES * K_MAX);
    localparam int MW  = 2 + FLW + SW;

    typedef struct packed {
        logic           known;
        logic           evict;
        logic [FLW-1:0] fill;
        logic [SW-1:0]  wptr;
    } meta_t;

    state_t state_reg, state_next;

    logic [3:0]             k_cfg_reg;
    logic [STAMP_WIDTH-1:0] clock_reg;
    logic [CW-1:0]          total_reg;
    logic [1:0]             op_reg;
    logic [FW-1:0]          frame_reg;
    logic [CW-1:0]          cnt_reg;
    logic                   s1_vld_reg;
    logic [FW-1:0]          s1_idx_reg;
    logic                   s2_vld_reg;
    logic [FW-1:0]          s2_idx_reg;
    meta_t                  s2_meta_reg;
    logic                   s2_inf_reg;
    logic                   s2_empty_reg;
    logic                   found_reg;
    logic                   best_inf_reg;
    logic [STAMP_WIDTH-1:0] best_key_reg;
    logic [FW-1:0]          best_idx_reg;
    meta_t                  best_meta_reg;
    logic [1:0]             status_reg;
    logic [5:0]             victim_reg;
    logic                   res_valid_reg;
    logic [1:0]             res_status_reg;
    logic [5:0]             res_victim_reg;
    logic [6:0]             res_count_reg;

    logic                   meta_we;
    logic [FW-1:0]          meta_waddr;
    logic [MW-1:0]          meta_wdata;
    logic [FW-1:0]          meta_raddr;
    logic [MW-1:0]          meta_rdata;
    logic                   stamp_we;
    logic [SAW-1:0]         stamp_waddr;
    logic [SAW-1:0]         stamp_raddr;
    logic [STAMP_WIDTH-1:0] stamp_rdata;

    logic                   accept;
    logic                   in_range;
    logic                   out_free;
    logic [4:0]             k_wide;
    logic [FLW-1:0]         k_eff;
    meta_t                  m_rd;
    meta_t                  m_pin;
    meta_t                  m_unpin;
    logic                   inf1;
    logic [FLW-1:0]         j1;
    logic [DW-1:0]          slot_wide;
    logic [SW-1:0]          slot1;
    logic [STAMP_WIDTH-1:0] key3;
    logic                   take3;

    assign accept   = item.valid && item.ready;
    assign in_range = ({26'd0, item.frame} < 32'(FRAMES));
    assign out_free = !res_valid_reg || result.ready;
    assign m_rd     = meta_t'(meta_rdata);

    // Metadata and stamp memories.
    lkr_ram #(.WIDTH(MW), .DEPTH(FRAMES)) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .raddr (meta_raddr),
        .rdata (meta_rdata)
    );

    lkr_ram #(.WIDTH(STAMP_WIDTH), .DEPTH(FRAMES * K_MAX)) u_stamp_ram (
        .clk   (clk),
        .we    (stamp_we),
        .waddr (stamp_waddr),
        .wdata (clock_reg),
        .raddr (stamp_raddr),
        .rdata (stamp_rdata)
    );

    // Effective K, clamped to the range one to K_MAX.
    always_comb
    begin
        k_wide = {1'b0, k_cfg_reg};
        if (k_wide == 5'd0)
        begin
            k_wide = 5'd1;
        end
        else if (k_wide > 5'(K_MAX))
        begin
            k_wide = 5'(K_MAX);
        end
        k_eff = FLW'(k_wide);
    end

    // Updated metadata for a pin and for an unpin of the frame just read.
    always_comb
    begin
        m_pin = m_rd;
        if (!m_rd.known)
        begin
            m_pin.known = 1'b1;
            m_pin.fill  = '0;
        end
        m_pin.evict = 1'b0;
        if (m_pin.wptr == SW'(K_MAX - 1))
        begin
            m_pin.wptr = '0;
        end
        else
        begin
            m_pin.wptr = m_pin.wptr + 1'b1;
        end
        if (m_pin.fill != FLW'(K_MAX))
        begin
            m_pin.fill = m_pin.fill + 1'b1;
        end
        m_unpin       = m_rd;
        m_unpin.evict = 1'b1;
    end

    // Scan stage one: choose which stamp of the frame sets its key.
    always_comb
    begin
        inf1      = (m_rd.fill < k_eff);
        j1        = inf1 ? m_rd.fill : k_eff;
        slot_wide = DW'(m_rd.wptr) + DW'(K_MAX) - DW'(j1);
        if (slot_wide >= DW'(K_MAX))
        begin
            slot_wide = slot_wide - DW'(K_MAX);
        end
        slot1 = SW'(slot_wide);
    end

    assign stamp_raddr = SAW'(s1_idx_reg) * SAW'(K_MAX) + SAW'(slot1);

    // Scan stage two: key of the frame and comparison against the best so far.
    always_comb
    begin
        if (s2_inf_reg)
        begin
            key3 = s2_empty_reg ? '0 : stamp_rdata;
        end
        else
        begin
            key3 = clock_reg - stamp_rdata;
        end
        take3 = s2_vld_reg && s2_meta_reg.evict &&
                (!found_reg ||
                 (s2_inf_reg && !best_inf_reg) ||
                 (s2_inf_reg && best_inf_reg && (key3 < best_key_reg)) ||
                 (!s2_inf_reg && !best_inf_reg && (key3 > best_key_reg)));
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (cnt_reg == CW'(FRAMES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (item.valid)
                begin
                    if (item.operation == OP_VICTIM)
                    begin
                        state_next = ST_SCAN;
                    end
                    else if (in_range &&
                             (item.operation == OP_PIN || item.operation == OP_UNPIN))
                    begin
                        state_next = ST_OP;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_OP:
            begin
                state_next = ST_DONE;
            end
            ST_SCAN:
            begin
                if (s2_vld_reg && s2_idx_reg == FW'(FRAMES - 1))
                begin
                    state_next = ST_VICT;
                end
            end
            ST_VICT:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Memory control and handshake outputs.
    always_comb
    begin
        meta_we     = 1'b0;
        meta_waddr  = frame_reg;
        meta_wdata  = '0;
        meta_raddr  = cnt_reg[FW-1:0];
        stamp_we    = 1'b0;
        stamp_waddr = SAW'(frame_reg) * SAW'(K_MAX) + SAW'(m_rd.wptr);
        item.ready  = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                meta_we    = 1'b1;
                meta_waddr = cnt_reg[FW-1:0];
            end
            ST_IDLE:
            begin
                item.ready = 1'b1;
                meta_raddr = FW'(item.frame);
            end
            ST_OP:
            begin
                if (op_reg == OP_PIN)
                begin
                    meta_we    = 1'b1;
                    meta_wdata = m_pin;
                    stamp_we   = 1'b1;
                end
                else
                begin
                    meta_we    = m_rd.known;
                    meta_wdata = m_unpin;
                end
            end
            ST_VICT:
            begin
                meta_we    = found_reg;
                meta_waddr = best_idx_reg;
                meta_wdata = {best_meta_reg.known, 1'b0, FLW'(0), best_meta_reg.wptr};
            end
            ST_SCAN, ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign cfg.ready              = 1'b1;
    assign result.valid           = res_valid_reg;
    assign result.status          = res_status_reg;
    assign result.victim_frame    = res_victim_reg;
    assign result.evictable_count = res_count_reg;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            k_cfg_reg     <= K_RESET;
            clock_reg     <= '0;
            total_reg     <= '0;
            cnt_reg       <= '0;
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
            found_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid)
            begin
                k_cfg_reg <= cfg.history_depth_k;
            end
            // The result register is loaded when a request finishes, else drained.
            if (state_reg == ST_DONE && out_free)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
            s2_vld_reg <= s1_vld_reg;
            s1_vld_reg <= (state_reg == ST_SCAN) && (cnt_reg < CW'(FRAMES));
            unique case (state_reg)
                ST_CLEAR:
                begin
                    cnt_reg <= (cnt_reg == CW'(FRAMES - 1)) ? '0 : cnt_reg + 1'b1;
                end
                ST_IDLE:
                begin
                    cnt_reg   <= '0;
                    found_reg <= 1'b0;
                end
                ST_OP:
                begin
                    if (op_reg == OP_PIN)
                    begin
                        if (clock_reg != '1)
                        begin
                            clock_reg <= clock_reg + 1'b1;
                        end
                        if (m_rd.known && m_rd.evict && total_reg != '0)
                        begin
                            total_reg <= total_reg - 1'b1;
                        end
                    end
                    else if (m_rd.known && !m_rd.evict)
                    begin
                        total_reg <= total_reg + 1'b1;
                    end
                end
                ST_SCAN:
                begin
                    if (cnt_reg < CW'(FRAMES))
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    if (take3)
                    begin
                        found_reg <= 1'b1;
                    end
                end
                ST_VICT:
                begin
                    if (found_reg && total_reg != '0)
                    begin
                        total_reg <= total_reg - 1'b1;
                    end
                end
                ST_DONE:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    // Payload registers of the request, the scan and the result.
    always_ff @(posedge clk)
    begin
        s1_idx_reg   <= cnt_reg[FW-1:0];
        s2_idx_reg   <= s1_idx_reg;
        s2_meta_reg  <= m_rd;
        s2_inf_reg   <= inf1;
        s2_empty_reg <= (m_rd.fill == '0);
        if (accept)
        begin
            op_reg     <= item.operation;
            frame_reg  <= FW'(item.frame);
            victim_reg <= '0;
            if (item.operation == OP_UNPIN && !in_range)
            begin
                status_reg <= STATUS_UNKNOWN;
            end
            else
            begin
                status_reg <= STATUS_OK;
            end
        end
        if (state_reg == ST_OP && op_reg == OP_UNPIN && !m_rd.known)
        begin
            status_reg <= STATUS_UNKNOWN;
        end
        if (state_reg == ST_SCAN && take3)
        begin
            best_inf_reg  <= s2_inf_reg;
            best_key_reg  <= key3;
            best_idx_reg  <= s2_idx_reg;
            best_meta_reg <= s2_meta_reg;
        end
        if (state_reg == ST_VICT)
        begin
            if (found_reg)
            begin
                victim_reg <= 6'(best_idx_reg);
            end
            else
            begin
                status_reg <= STATUS_EMPTY;
            end
        end
        if (state_reg == ST_DONE && out_free)
        begin
            res_status_reg <= status_reg;
            res_victim_reg <= victim_reg;
            res_count_reg  <= 7'(total_reg);
        end
    end

endmodule

// ===== rtl/lkr_ram.sv =====
// Simple dual-port synchronous RAM with registered read.
module lkr_ram
    import lkr_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== tb/lru_k_frame_replacer_top_tb.sv =====
// Self-checking testbench of the LRU-K frame replacer: directed table, random traffic, predictor.
module lru_k_frame_replacer_top_tb;
    import lkr_pkg::*;

    localparam int NFR  = 64;
    localparam int KMX  = 8;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 400;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] victim_frame;
        logic [6:0] evictable_count;
    } outcome_t;

    typedef struct {
        logic [1:0] operation;
        logic [5:0] frame;
        bit         typed;
        outcome_t   want;
    } row_t;

    logic clk;
    logic rst_n;

    lkr_cfg_if    cfg ();
    lkr_item_if   item ();
    lkr_result_if result ();

    lru_k_frame_replacer_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg.sink),
        .item   (item.sink),
        .result (result.source)
    );

    // Replacer state mirrored by the predictor.
    logic [3:0]  depth_reg;
    logic [31:0] stamp_clock;
    int          evict_total;
    bit          known [NFR];
    bit          evictable [NFR];
    int          fill [NFR];
    logic [31:0] stamps [NFR][KMX];

    outcome_t pending_outcomes [$];
    int  errors;
    int  idle_cycles;
    bit  quiet;
    bit  hold_long;

    // Reports one mismatch and counts it.
    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    function automatic void predictor_reset();
        depth_reg = K_RESET;
        stamp_clock = 0;
        evict_total = 0;
        for (int i = 0; i < NFR; i++)
        begin
            known[i] = 0;
            evictable[i] = 0;
            fill[i] = 0;
        end
    endfunction

    // Works out one result and updates the mirrored state.
    function automatic outcome_t predict_replacer(input logic [1:0] op, input logic [5:0] f);
        outcome_t o;
        int k;
        bit found;
        bit best_inf;
        bit inf;
        logic [31:0] best_key;
        logic [31:0] key;
        int best;
        o.status = STATUS_OK;
        o.victim_frame = 0;
        if (op == OP_PIN)
        begin
            if (!known[f])
            begin
                known[f] = 1;
                evictable[f] = 0;
                fill[f] = 0;
            end
            else if (evictable[f])
            begin
                evictable[f] = 0;
                if (evict_total > 0) evict_total--;
            end
            for (int i = KMX - 1; i > 0; i--) stamps[f][i] = stamps[f][i - 1];
            stamps[f][0] = stamp_clock;
            if (fill[f] < KMX) fill[f]++;
            if (stamp_clock != 32'hFFFF_FFFF) stamp_clock++;
        end
        else if (op == OP_UNPIN)
        begin
            if (known[f])
            begin
                if (!evictable[f])
                begin
                    evictable[f] = 1;
                    evict_total++;
                end
            end
            else
                o.status = STATUS_UNKNOWN;
        end
        else if (op == OP_VICTIM)
        begin
            k = (depth_reg == 0) ? 1 : (depth_reg > KMX) ? KMX : depth_reg;
            found = 0;
            best_inf = 0;
            best_key = 0;
            best = 0;
            for (int i = 0; i < NFR; i++)
            begin
                if (evictable[i])
                begin
                    inf = fill[i] < k;
                    if (inf)
                        key = (fill[i] == 0) ? 32'd0 : stamps[i][fill[i] - 1];
                    else
                        key = stamp_clock - stamps[i][k - 1];
                    if (!found)
                    begin
                        found = 1; best = i; best_inf = inf; best_key = key;
                    end
                    else if (inf && !best_inf)
                    begin
                        best = i; best_inf = 1; best_key = key;
                    end
                    else if (inf && best_inf)
                    begin
                        if (key < best_key) begin best = i; best_key = key; end
                    end
                    else if (!inf && !best_inf)
                    begin
                        if (key > best_key) begin best = i; best_key = key; end
                    end
                end
            end
            if (!found)
                o.status = STATUS_EMPTY;
            else
            begin
                fill[best] = 0;
                evictable[best] = 0;
                if (evict_total > 0) evict_total--;
                o.victim_frame = best[5:0];
            end
        end
        o.evictable_count = evict_total[6:0];
        return o;
    endfunction

    // Clock.
    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // Watchdog over cycles without any transaction.
    always @(posedge clk)
    begin
        if ((item.valid && item.ready) || (result.valid && result.ready) ||
            (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result checker against the oldest expectation.
    always @(posedge clk)
    begin
        outcome_t w;
        if (rst_n && result.valid && result.ready)
        begin
            if (pending_outcomes.size() == 0)
                report("unexpected result", result.status, -1);
            else
            begin
                w = pending_outcomes.pop_front();
                if (result.status !== w.status)
                    report("status", result.status, w.status);
                if (result.victim_frame !== w.victim_frame)
                    report("victim_frame", result.victim_frame, w.victim_frame);
                if (result.evictable_count !== w.evictable_count)
                    report("evictable_count", result.evictable_count, w.evictable_count);
            end
        end
    end

    // Receiver: random stalls in bursts, one long hold-off, none near the end.
    initial
    begin
        int n;
        result.ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_long)
            begin
                result.ready <= 0;
                repeat (600) @(posedge clk);
                hold_long = 0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 5);
                result.ready <= 0;
                repeat (n - 1) @(posedge clk);
            end
            else
                result.ready <= 1;
        end
    end

    // Offers one request transaction and records its expectation on acceptance.
    task automatic send_request(input logic [1:0] op, input logic [5:0] f,
                                input bit typed, input outcome_t want);
        outcome_t p;
        int n;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            n = $urandom_range(1, 5);
            item.valid <= 0;
            repeat (n) @(posedge clk);
        end
        item.valid <= 1;
        item.operation <= op;
        item.frame <= f;
        do @(posedge clk); while (!item.ready);
        p = predict_replacer(op, f);
        if (typed && p !== want)
            report("table row", p, want);
        pending_outcomes.push_back(typed ? want : p);
    endtask

    // Waits until the block is idle, then writes the depth register.
    task automatic write_depth(input logic [3:0] k);
        item.valid <= 0;
        while (pending_outcomes.size() != 0) @(posedge clk);
        repeat (NFR + 8) @(posedge clk);
        cfg.valid <= 1;
        cfg.history_depth_k <= k;
        do @(posedge clk); while (!cfg.ready);
        depth_reg = k;
        cfg.valid <= 0;
    endtask

    // Mostly pins and unpins over a frame pool, with victims and unused codes among them.
    task automatic random_phase(input int count, input int pool);
        logic [1:0] op;
        logic [5:0] f;
        int r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            op = (r < 45) ? OP_PIN : (r < 75) ? OP_UNPIN : (r < 97) ? OP_VICTIM : 2'd3;
            f = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, pool - 1));
            send_request(op, f, 0, '0);
        end
    endtask

    row_t rows [$];

    function automatic row_t mk(input logic [1:0] op, input logic [5:0] f,
                                input bit typed, input outcome_t want);
        row_t r;
        r.operation = op;
        r.frame = f;
        r.typed = typed;
        r.want = want;
        return r;
    endfunction

    // Stimulus sequence.
    initial
    begin
        errors = 0;
        idle_cycles = 0;
        quiet = 0;
        hold_long = 0;
        rst_n = 0;
        cfg.valid = 0;
        cfg.history_depth_k = 0;
        item.valid = 0;
        item.operation = 0;
        item.frame = 0;
        predictor_reset();
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed table: typed rows where the answer is plain, others predicted.
        rows.push_back(mk(OP_VICTIM, 6'd0, 1, '{STATUS_EMPTY, 6'd0, 7'd0}));
        rows.push_back(mk(OP_UNPIN, 6'd63, 1, '{STATUS_UNKNOWN, 6'd0, 7'd0}));
        rows.push_back(mk(2'd3, 6'd17, 1, '{STATUS_OK, 6'd0, 7'd0}));
        rows.push_back(mk(OP_PIN, 6'd63, 1, '{STATUS_OK, 6'd0, 7'd0}));
        rows.push_back(mk(OP_PIN, 6'd0, 1, '{STATUS_OK, 6'd0, 7'd0}));
        rows.push_back(mk(OP_UNPIN, 6'd63, 1, '{STATUS_OK, 6'd0, 7'd1}));
        rows.push_back(mk(OP_UNPIN, 6'd63, 1, '{STATUS_OK, 6'd0, 7'd1}));
        rows.push_back(mk(OP_UNPIN, 6'd0, 1, '{STATUS_OK, 6'd0, 7'd2}));
        rows.push_back(mk(OP_PIN, 6'd63, 1, '{STATUS_OK, 6'd0, 7'd1}));
        rows.push_back(mk(OP_UNPIN, 6'd63, 0, '0));
        rows.push_back(mk(OP_PIN, 6'd42, 0, '0));
        rows.push_back(mk(OP_PIN, 6'd42, 0, '0));
        rows.push_back(mk(OP_UNPIN, 6'd42, 0, '0));
        rows.push_back(mk(OP_VICTIM, 6'd63, 0, '0));
        rows.push_back(mk(OP_VICTIM, 6'd21, 0, '0));
        rows.push_back(mk(OP_VICTIM, 6'd0, 0, '0));
        rows.push_back(mk(OP_VICTIM, 6'd0, 0, '0));
        rows.push_back(mk(OP_UNPIN, 6'd21, 1, '{STATUS_UNKNOWN, 6'd0, 7'd0}));
        rows.push_back(mk(OP_UNPIN, 6'd42, 0, '0));
        rows.push_back(mk(OP_PIN, 6'd42, 0, '0));
        foreach (rows[i])
            send_request(rows[i].operation, rows[i].frame, rows[i].typed, rows[i].want);

        // Random phases across depth settings, extremes and out-of-range included.
        random_phase(80, 8);
        write_depth(4'd0);
        random_phase(60, 12);
        write_depth(4'd1);
        hold_long = 1;
        random_phase(60, 64);
        write_depth(4'd8);
        random_phase(60, 6);
        write_depth(4'd15);
        random_phase(60, 10);
        write_depth(4'd3);
        random_phase(40, 16);
        quiet = 1;
        random_phase(40, 8);
        item.valid <= 0;

        while (pending_outcomes.size() != 0) @(posedge clk);
        repeat (NFR + 8) @(posedge clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/lkr_pkg.sv
rtl/lkr_if.sv
rtl/lkr_ram.sv
rtl/lru_k_frame_replacer_top.sv
tb/lru_k_frame_replacer_top_tb.sv
